>>> rtl/blue_screen_chroma_key_pixel_core_macros.svh
// Assertion macros for the blue-screen chroma key core.
`ifndef BLUE_SCREEN_CHROMA_KEY_PIXEL_CORE_MACROS_SVH
`define BLUE_SCREEN_CHROMA_KEY_PIXEL_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BSCK_ASSERT_IMPLIES(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("chroma key check failed");
// Next-cycle implication.
`define BSCK_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("chroma key check failed");
`else
`define BSCK_ASSERT_IMPLIES(lbl, pre, post)
`define BSCK_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> rtl/bsck_pkg.sv
// Shared types and constants for the blue-screen chroma key core.
package bsck_pkg;

   localparam int CHAN_W         = 8;
   localparam int DIST_W         = 9;
   localparam int NUM_W          = 17;
   localparam int PROD_W         = 16;
   localparam int CSR_IDX_W      = 1;
   localparam int DIV_STAGES     = 4;
   localparam int BITS_PER_STAGE = 2;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
   localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_DIST_LOW  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_HIGH = 1'b1;

   localparam logic [DIST_W-1:0] DIST_LOW_RST  = 9'd25;
   localparam logic [DIST_W-1:0] DIST_HIGH_RST = 9'd75;

   typedef enum logic [1:0] {
      KEY_OPAQUE = 2'd0,
      KEY_CLEAR  = 2'd1,
      KEY_RAMP   = 2'd2
   } key_region_type;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   // Effective thresholds, low always below high.
   typedef struct packed {
      logic [DIST_W-1:0] low;
      logic [DIST_W-1:0] high;
   } thresh_type;

   typedef struct packed {
      pixel_type         pix;
      key_region_type    region;
      logic [NUM_W-1:0]  rem;
      logic [DIST_W-1:0] den;
      logic [CHAN_W-1:0] quo;
   } div_type;

   typedef struct packed {
      pixel_type         pix;
      logic [CHAN_W-1:0] alpha;
   } result_type;

endpackage

>>> rtl/bsck_csr.sv
// Threshold registers and their effective values.
module bsck_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bsck_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bsck_pkg::DIST_W-1:0]      csr_data,
   output bsck_pkg::thresh_type             thresh
);
   import bsck_pkg::*;

   logic [DIST_W-1:0] low_ff, low_in;
   logic [DIST_W-1:0] high_ff, high_in;
   logic [DIST_W-1:0] high_eff;

   assign csr_ready = 1'b1;

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DIST_LOW:  low_in  = csr_data;
            CSR_DIST_HIGH: high_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= DIST_LOW_RST;
         high_ff <= DIST_HIGH_RST;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   // zero high treated as one; low clamped to high-1
   assign high_eff    = (high_ff == '0) ? DIST_W'(1) : high_ff;
   assign thresh.high = high_eff;
   assign thresh.low  = (low_ff >= high_eff) ? high_eff - DIST_W'(1) : low_ff;

endmodule

>>> rtl/bsck_key.sv
// Front stages: candidate test, blue excess and ramp numerator.
module bsck_key (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bsck_pkg::pixel_type  in_pix,
   input  bsck_pkg::thresh_type thresh,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bsck_pkg::div_type    out_data
);
   import bsck_pkg::*;

   typedef struct packed {
      pixel_type         pix;
      logic              cand;
      logic [DIST_W-1:0] excess;
   } front_type;

   front_type         st1_ff, st1_in;
   div_type           st2_ff, st2_in;
   logic              v1_ff, v1_in;
   logic              v2_ff, v2_in;
   logic              en1, en2;
   logic [DIST_W:0]   dist_wide;
   logic [DIST_W-1:0] diff;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // stage 1: blue largest (ties count) and 2b-g-r
   always_comb begin
      dist_wide     = {1'b0, in_pix.blue, 1'b0} - {2'b00, in_pix.green}
                      - {2'b00, in_pix.red};
      st1_in.pix    = in_pix;
      st1_in.cand   = (in_pix.blue >= in_pix.green) && (in_pix.blue >= in_pix.red);
      st1_in.excess = dist_wide[DIST_W-1:0];
      v1_in         = en1 ? in_valid : v1_ff;
   end

   // stage 2: region and 255*(high-d) over (high-low)
   always_comb begin
      diff          = thresh.high - st1_ff.excess;
      st2_in.pix    = st1_ff.pix;
      st2_in.rem    = {diff, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, diff};
      st2_in.den    = thresh.high - thresh.low;
      st2_in.quo    = '0;
      if (!st1_ff.cand || (st1_ff.excess < thresh.low)) begin
         st2_in.region = KEY_OPAQUE;
      end else if (st1_ff.excess > thresh.high) begin
         st2_in.region = KEY_CLEAR;
      end else begin
         st2_in.region = KEY_RAMP;
      end
      v2_in = en2 ? v1_ff : v2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         st1_ff <= st1_in;
      end
      if (en2) begin
         st2_ff <= st2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = st2_ff;

endmodule

>>> rtl/bsck_div.sv
// Pipelined restoring divider for the alpha ramp, two quotient bits a stage.
module bsck_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  bsck_pkg::div_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output bsck_pkg::div_type out_data
);
   import bsck_pkg::*;

   div_type st_ff [DIV_STAGES];
   div_type st_in [DIV_STAGES];
   div_type src   [DIV_STAGES];
   logic    v_ff  [DIV_STAGES];
   logic    src_v [DIV_STAGES];
   logic    en    [DIV_STAGES];

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
      localparam int SH_HI = CHAN_W - 1 - BITS_PER_STAGE * j;

      logic [NUM_W-1:0] trial;
      div_type          nxt;

      if (j == 0) begin : g_first
         assign src[j]   = in_data;
         assign src_v[j] = in_valid;
      end else begin : g_rest
         assign src[j]   = st_ff[j-1];
         assign src_v[j] = v_ff[j-1];
      end

      if (j == DIV_STAGES - 1) begin : g_last
         assign en[j] = !v_ff[j] || out_ready;
      end else begin : g_mid
         assign en[j] = !v_ff[j] || en[j+1];
      end

      always_comb begin
         nxt   = src[j];
         trial = '0;
         for (int k = 0; k < BITS_PER_STAGE; k++) begin
            trial = {{(NUM_W-DIST_W){1'b0}}, nxt.den} << (SH_HI - k);
            if (nxt.rem >= trial) begin
               nxt.rem              = nxt.rem - trial;
               nxt.quo[SH_HI - k]   = 1'b1;
            end
         end
         st_in[j] = nxt;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en[j]) begin
            v_ff[j] <= src_v[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            st_ff[j] <= st_in[j];
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_data  = st_ff[DIV_STAGES-1];

endmodule

>>> rtl/bsck_blend.sv
// Back stages: alpha select and blend toward white with exact divide by 255.
module bsck_blend (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bsck_pkg::div_type    in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bsck_pkg::result_type out_data
);
   import bsck_pkg::*;

   typedef struct packed {
      logic [2:0][PROD_W-1:0] prod;
      logic [CHAN_W-1:0]      alpha;
   } prod_stage_type;

   typedef struct packed {
      logic [2:0][PROD_W-1:0] prod;
      logic [2:0][CHAN_W-1:0] est;
      logic [CHAN_W-1:0]      alpha;
   } est_stage_type;

   prod_stage_type          st7_ff, st7_in;
   est_stage_type           st8_ff, st8_in;
   result_type              st9_ff, st9_in;
   logic                    v7_ff, v7_in;
   logic                    v8_ff, v8_in;
   logic                    v9_ff, v9_in;
   logic                    en7, en8, en9;
   logic [2:0][CHAN_W-1:0]  chan;
   logic [CHAN_W-1:0]       alpha;
   logic [2:0][23:0]        scaled;
   logic [2:0][PROD_W-1:0]  back;
   logic [2:0][PROD_W-1:0]  resid;
   logic [2:0][CHAN_W-1:0]  quo;
   logic [2:0][CHAN_W-1:0]  blended;

   assign en9      = !v9_ff || out_ready;
   assign en8      = !v8_ff || en9;
   assign en7      = !v7_ff || en8;
   assign in_ready = en7;

   // channel 0 blue, 1 green, 2 red
   assign chan[0] = in_data.pix.blue;
   assign chan[1] = in_data.pix.green;
   assign chan[2] = in_data.pix.red;

   // stage 7: alpha and c*alpha; a pass-through pixel has alpha 255,
   // which the blend leaves unchanged
   always_comb begin
      case (in_data.region)
         KEY_OPAQUE: alpha = ALPHA_OPAQUE;
         KEY_CLEAR:  alpha = ALPHA_CLEAR;
         KEY_RAMP:   alpha = in_data.quo;
         default:    alpha = ALPHA_OPAQUE;
      endcase
      for (int c = 0; c < 3; c++) begin
         st7_in.prod[c] = {{CHAN_W{1'b0}}, chan[c]} * {{CHAN_W{1'b0}}, alpha};
      end
      st7_in.alpha = alpha;
      v7_in        = en7 ? in_valid : v7_ff;
   end

   // stage 8: estimate x/255 as x*257 >> 16, at most one low
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         scaled[c]     = {st7_ff.prod[c], {CHAN_W{1'b0}}}
                         + {{CHAN_W{1'b0}}, st7_ff.prod[c]};
         st8_in.est[c] = scaled[c][23:16];
      end
      st8_in.prod  = st7_ff.prod;
      st8_in.alpha = st7_ff.alpha;
      v8_in        = en8 ? v7_ff : v8_ff;
   end

   // stage 9: correct the estimate, add the white share
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         back[c]    = {st8_ff.est[c], {CHAN_W{1'b0}}}
                      - {{CHAN_W{1'b0}}, st8_ff.est[c]};
         resid[c]   = st8_ff.prod[c] - back[c];
         quo[c]     = (resid[c] >= PROD_W'(ALPHA_OPAQUE))
                      ? st8_ff.est[c] + CHAN_W'(1) : st8_ff.est[c];
         blended[c] = (ALPHA_OPAQUE - st8_ff.alpha) + quo[c];
      end
      st9_in.pix.blue  = blended[0];
      st9_in.pix.green = blended[1];
      st9_in.pix.red   = blended[2];
      st9_in.alpha     = st8_ff.alpha;
      v9_in            = en9 ? v8_ff : v9_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else begin
         v7_ff <= v7_in;
         v8_ff <= v8_in;
         v9_ff <= v9_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en7) begin
         st7_ff <= st7_in;
      end
      if (en8) begin
         st8_ff <= st8_in;
      end
      if (en9) begin
         st9_ff <= st9_in;
      end
   end

   assign out_valid = v9_ff;
   assign out_data  = st9_ff;

endmodule

>>> rtl/blue_screen_chroma_key_pixel_core.sv
// Blue-screen chroma key core: one BGR pixel in, keyed BGR plus alpha out.
// Pipeline: nine register stages, four of them the ramp divider.
// Throughput: one pixel per cycle while rsp_ready does not stall the output.
// A stalled output backs up stage by stage; empty stages keep taking beats meanwhile.
// Reset (synchronous, active high) empties the pipe and sets thresholds to 25 and 75.
`include "blue_screen_chroma_key_pixel_core_macros.svh"

module blue_screen_chroma_key_pixel_core (
   input  logic                           clock,
   input  logic                           reset,
   // pixel input beat
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bsck_pkg::CHAN_W-1:0]    req_blue_in,
   input  logic [bsck_pkg::CHAN_W-1:0]    req_green_in,
   input  logic [bsck_pkg::CHAN_W-1:0]    req_red_in,
   // keyed pixel output beat
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bsck_pkg::CHAN_W-1:0]    rsp_blue_out,
   output logic [bsck_pkg::CHAN_W-1:0]    rsp_green_out,
   output logic [bsck_pkg::CHAN_W-1:0]    rsp_red_out,
   output logic [bsck_pkg::CHAN_W-1:0]    rsp_alpha_out,
   // threshold writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bsck_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bsck_pkg::DIST_W-1:0]    csr_data
);
   import bsck_pkg::*;

   thresh_type thresh;
   pixel_type  in_pix;
   div_type    key_data, div_data;
   result_type res_data;
   logic       key_valid, key_ready;
   logic       div_valid, div_ready;

   assign in_pix.blue  = req_blue_in;
   assign in_pix.green = req_green_in;
   assign in_pix.red   = req_red_in;

   // Threshold registers; effective values clamped so low < high always.
   bsck_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .thresh    (thresh)
   );

   // Stages 1-2: candidate test (blue largest, ties count), blue excess,
   // region select and the ramp numerator 255*(high-d).
   bsck_key u_key (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_pix    (in_pix),
      .thresh    (thresh),
      .out_valid (key_valid),
      .out_ready (key_ready),
      .out_data  (key_data)
   );

   // Stages 3-6: quotient is at most 255, so eight restoring steps suffice.
   // Off-ramp beats run through as well; their quotient is discarded later.
   bsck_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (key_valid),
      .in_ready  (key_ready),
      .in_data   (key_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   // Stages 7-9: alpha select, c*alpha, divide by 255 via reciprocal plus
   // one correction, then add 255-alpha. Stage 9 is the output register.
   bsck_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (res_data)
   );

   assign rsp_blue_out  = res_data.pix.blue;
   assign rsp_green_out = res_data.pix.green;
   assign rsp_red_out   = res_data.pix.red;
   assign rsp_alpha_out = res_data.alpha;

   // An empty output stage opens the whole ready chain.
   `BSCK_ASSERT_IMPLIES(a_ready_when_out_empty, !rsp_valid, req_ready)
   // Fully keyed-out pixels blend to pure white.
   `BSCK_ASSERT_IMPLIES(a_clear_is_white, rsp_valid && (rsp_alpha_out == ALPHA_CLEAR), (rsp_blue_out == ALPHA_OPAQUE) && (rsp_green_out == ALPHA_OPAQUE) && (rsp_red_out == ALPHA_OPAQUE))
   // Clamped thresholds keep the ramp divisor non-zero.
   `BSCK_ASSERT_IMPLIES(a_thresh_order, 1'b1, thresh.low < thresh.high)
   // A non-zero high threshold is used as written.
   `BSCK_ASSERT_NEXT(a_high_taken, csr_valid && csr_ready && (csr_index == CSR_DIST_HIGH) && (csr_data != '0), thresh.high == $past(csr_data))

endmodule
